[sv/vwd_pkg.sv]
`timescale 1ns / 1ps

package vwd_pkg;

  // store depth and derived widths
  localparam int MAX_VERTS = 256;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);

  localparam int POS_W  = 32;
  localparam int NORM_W = 16;
  localparam int RAD_W  = 31;
  localparam int OUT_IDX_W = 8;

  // compare pipeline depth, stored entry to registered hit
  localparam int DIST_LAT = 3;

  localparam logic [RAD_W-1:0]  WELD_RESET = RAD_W'(655);
  localparam logic [NORM_W-1:0] NORM_UP    = NORM_W'(16384);

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                     mesh_start;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  tex_u;
    logic signed [POS_W-1:0]  tex_v;
    logic                     has_tex;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     has_norm;
  } vtx_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]     vertex_index;
    logic                     is_new;
    logic                     store_full;
    logic signed [POS_W-1:0]  weld_x;
    logic signed [POS_W-1:0]  weld_y;
    logic signed [POS_W-1:0]  weld_z;
    logic signed [POS_W-1:0]  weld_u;
    logic signed [POS_W-1:0]  weld_v;
    logic signed [NORM_W-1:0] weld_nx;
    logic signed [NORM_W-1:0] weld_ny;
    logic signed [NORM_W-1:0] weld_nz;
  } vtx_out_t;

  // entry tag going into the compare pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // compare result coming back
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } hit_t;

endpackage

[sv/vwd_cell.sv]
`timescale 1ns / 1ps

// one stored position of the circulating ring
module vwd_cell import vwd_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  logic load,
  input  pos_t nbr,
  input  pos_t din,
  output pos_t q
);

  pos_t entry;

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= din;
    end else if (shift) begin
      entry <= nbr;
    end
  end

  assign q = entry;

endmodule

[sv/vwd_dist.sv]
`timescale 1ns / 1ps

// three-stage squared distance test: abs diff, square, sum and compare
module vwd_dist import vwd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RAD_W-1:0] radius,
  input  pos_t             probe,
  input  pos_t             stored,
  input  tag_t             tag,
  output hit_t             result
);

  localparam int SQ_W = 2 * RAD_W;

  logic [SQ_W-1:0] radius_sq;

  logic signed [POS_W:0] dx, dy, dz;
  logic [POS_W:0]        ax, ay, az;
  logic                  over_a;

  // stage a
  tag_t             tag_a;
  logic             over_a_q;
  logic [RAD_W-1:0] ax_q, ay_q, az_q;

  // stage b
  tag_t            tag_b;
  logic            over_b;
  logic [SQ_W-1:0] sx, sy, sz;

  logic [SQ_W+1:0] sum;

  always_ff @(posedge clk) begin
    radius_sq <= SQ_W'(radius) * SQ_W'(radius);
  end

  always_comb begin
    dx = {stored.x[POS_W-1], stored.x} - {probe.x[POS_W-1], probe.x};
    dy = {stored.y[POS_W-1], stored.y} - {probe.y[POS_W-1], probe.y};
    dz = {stored.z[POS_W-1], stored.z} - {probe.z[POS_W-1], probe.z};
    ax = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
    ay = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
    az = dz[POS_W] ? (POS_W+1)'(-dz) : (POS_W+1)'(dz);
    over_a = (ax > (POS_W+1)'(radius)) || (ay > (POS_W+1)'(radius))
          || (az > (POS_W+1)'(radius));
  end

  always_ff @(posedge clk) begin
    ax_q     <= ax[RAD_W-1:0];
    ay_q     <= ay[RAD_W-1:0];
    az_q     <= az[RAD_W-1:0];
    over_a_q <= over_a;
    sx       <= SQ_W'(ax_q) * SQ_W'(ax_q);
    sy       <= SQ_W'(ay_q) * SQ_W'(ay_q);
    sz       <= SQ_W'(az_q) * SQ_W'(az_q);
    over_b   <= over_a_q;
  end

  assign sum = (SQ_W+2)'(sx) + (SQ_W+2)'(sy) + (SQ_W+2)'(sz);

  always_ff @(posedge clk) begin
    tag_a.idx  <= tag.idx;
    tag_b.idx  <= tag_a.idx;
    result.idx <= tag_b.idx;
    if (rst) begin
      tag_a.valid <= 1'b0;
      tag_b.valid <= 1'b0;
      result.hit  <= 1'b0;
    end else begin
      tag_a.valid <= tag.valid;
      tag_b.valid <= tag_a.valid;
      result.hit  <= tag_b.valid && !over_b && (sum <= (SQ_W+2)'(radius_sq));
    end
  end

endmodule

[sv/vertex_weld_dedup_core.sv]
`timescale 1ns / 1ps

// vertex welding by brute-force search. a vertex transfer is taken when start
// is high and busy is low; its position is tested against every unique vertex
// kept so far and exactly one result transfer follows, flagged by done for a
// single cycle. the receiver cannot stall, so done is never held back. the
// unique positions sit in a ring of MAX_VERTS cells that rotates by one cell
// per clock while scanning, past a single three-stage distance test, so every
// vertex scans the whole ring and then drains the test, whatever the fill
// level. a new vertex may be started in the cycle its result is shown.
// the user must write weld_distance through weld_distance_we /
// weld_distance_wdata only while idle; the block itself does not enforce
// this. it resets to 655 (0.01 in Q15.16).
module vertex_weld_dedup_core import vwd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vtx_in_t          item,
  output logic             done,
  output vtx_out_t         result,
  input  logic             weld_distance_we,
  input  logic [RAD_W-1:0] weld_distance_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  localparam int DRN_W = $clog2(DIST_LAT + 1);

  logic [1:0]       state;
  logic [RAD_W-1:0] weld_distance;
  logic [CNT_W-1:0] unique_count;
  logic [IDX_W-1:0] step;
  logic [DRN_W-1:0] drain;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  vtx_in_t          held;
  vtx_out_t         result_next;

  pos_t entry [MAX_VERTS];
  pos_t probe;
  tag_t tag;
  hit_t hit;

  logic shift;
  logic append;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign shift  = (state == ST_SCAN);

  // append only when the search came up empty and there is room
  assign append = (state == ST_FINAL) && !found
               && (unique_count < CNT_W'(MAX_VERTS));

  assign probe = '{x: held.pos_x, y: held.pos_y, z: held.pos_z};

  // ring of cells, cell 0 is the head seen by the distance test
  for (genvar k = 0; k < MAX_VERTS; k++) begin : g_ring
    localparam int NXT = (k + 1) % MAX_VERTS;
    vwd_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .load  (append && (unique_count[IDX_W-1:0] == IDX_W'(k))),
      .nbr   (entry[NXT]),
      .din   (probe),
      .q     (entry[k])
    );
  end

  // head holds entry number step while scanning
  assign tag.valid = shift && ({1'b0, step} < (IDX_W+1)'(unique_count));
  assign tag.idx   = step;

  vwd_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .radius (weld_distance),
    .probe  (probe),
    .stored (entry[0]),
    .tag    (tag),
    .result (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weld_distance <= WELD_RESET;
    end else if (weld_distance_we) begin
      weld_distance <= weld_distance_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

  // sequencer: scan the full ring so it comes back home, drain, decide
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      unique_count <= '0;
      step         <= '0;
      drain        <= '0;
      found        <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= (state == ST_FINAL);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            step  <= '0;
            found <= 1'b0;
            if (item.mesh_start) begin
              unique_count <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (step == IDX_W'(MAX_VERTS - 1)) begin
            state <= ST_DRAIN;
            step  <= '0;
            drain <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (drain == DRN_W'(DIST_LAT - 1)) begin
            state <= ST_FINAL;
          end else begin
            drain <= drain + 1'b1;
          end
        end
        ST_FINAL: begin
          state <= ST_IDLE;
          if (append) begin
            unique_count <= unique_count + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // first match wins, entries come back in index order
      if (hit.hit && !found && (state != ST_IDLE)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit.hit && !found) begin
      found_idx <= hit.idx;
    end
  end

  // result word for the decision cycle
  always_comb begin
    result_next = '0;
    if (found) begin
      result_next.vertex_index = OUT_IDX_W'(found_idx);
    end else if (append) begin
      result_next.vertex_index = OUT_IDX_W'(unique_count);
      result_next.is_new       = 1'b1;
      result_next.weld_x       = held.pos_x;
      result_next.weld_y       = held.pos_y;
      result_next.weld_z       = held.pos_z;
      if (held.has_tex) begin
        result_next.weld_u = held.tex_u;
        result_next.weld_v = held.tex_v;
      end
      if (held.has_norm) begin
        result_next.weld_nx = held.norm_x;
        result_next.weld_ny = held.norm_y;
        result_next.weld_nz = held.norm_z;
      end else begin
        result_next.weld_nz = NORM_UP;
      end
    end else begin
      result_next.store_full = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_FINAL) begin
      result <= result_next;
    end
  end

endmodule
